### hdl/newton_square_root_defines.svh
// Shared assertion macros. The checker that uses them has ports named i_clk and i_rst_n.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define NSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define NSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/nsr_pkg.sv
package nsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths of the ports
    localparam int FIELD_BITS   = 32;
    localparam int STEP_BITS    = 8;
    localparam int OUTCOME_BITS = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [FIELD_BITS-1:0] TOL_RESET   = FIELD_BITS'(65);
    localparam logic [STEP_BITS-1:0]  LIMIT_RESET = STEP_BITS'(64);

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_CONVERGED  = 2'd0,
        OUT_LIMIT      = 2'd1,
        OUT_ZERO_GUESS = 2'd2
    } t_outcome;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TOLERANCE  = 1'b0,
        CFG_STEP_LIMIT = 1'b1
    } t_cfg_index;

endpackage

### hdl/nsr_sqr.sv
// Shift-and-add squarer: one multiplier bit per cycle.
module nsr_sqr import nsr_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [WORD_BITS-1:0]     i_operand,
    output logic                     o_done,
    output logic [2*WORD_BITS-1:0]   o_product
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_opd;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_mlo;
    logic [WORD_BITS:0]   n_sum;

    assign n_sum = {1'b0, r_acc} + (r_mlo[0] ? {1'b0, r_opd} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(WORD_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Add on the low multiplier bit, then shift the whole product right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_opd <= i_operand;
            r_mlo <= i_operand;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_acc <= n_sum[WORD_BITS:1];
            r_mlo <= {n_sum[0], r_mlo[WORD_BITS-1:1]};
        end
    end

    assign o_done    = (r_cnt == '0);
    assign o_product = {r_acc, r_mlo};

endmodule

### hdl/nsr_div.sv
// Restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
// Quotient saturates at 2^(WORD_BITS+1)-1.
module nsr_div import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [WORD_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [WORD_BITS:0]   o_quotient
);

    localparam int DQ_BITS  = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(DQ_BITS + 1);

    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_dvs;
    logic [WORD_BITS-1:0] r_rem;
    logic [DQ_BITS-1:0]   r_dq;
    logic [WORD_BITS:0]   n_trial;
    logic [WORD_BITS:0]   n_diff;
    logic                 n_ge;
    logic                 quot_sat;

    assign n_trial = {r_rem, r_dq[DQ_BITS-1]};
    assign n_diff  = n_trial - {1'b0, r_dvs};
    assign n_ge    = (n_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(DQ_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Dividend bits leave at the top as quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_dq  <= {i_dividend, {FRAC_BITS{1'b0}}};
        end else if (r_cnt != '0) begin
            r_rem <= n_ge ? n_diff[WORD_BITS-1:0] : n_trial[WORD_BITS-1:0];
            r_dq  <= {r_dq[DQ_BITS-2:0], n_ge};
        end
    end

    assign quot_sat   = |r_dq[DQ_BITS-1:WORD_BITS+1];
    assign o_done     = (r_cnt == '0);
    assign o_quotient = quot_sat ? '1 : r_dq[WORD_BITS:0];

endmodule

### hdl/newton_square_root.sv
// Newton-Raphson square root of an unsigned fixed-point radicand.
// Input channel: i_in_valid / o_in_stall carry one request (radicand, start guess);
// a request is taken on a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry root, steps taken and outcome;
// a result is taken on a rising edge with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data to the register picked by i_cfg_index
// (0 tolerance, 1 step limit); write only while no request is in flight.
// A zero start guess goes from acceptance straight to the emit state; otherwise the
// block loops through the load, square and divide states until the stop test or the
// step limit ends the descent.
// Each step is bounded by the bit-serial divider, one quotient bit per cycle;
// the bit-serial squarer for the stop test runs alongside it.
// One request is worked on at a time; a new one is taken the cycle after the
// result is loaded into the output register, even while that result is stalled.
// A finished result waits in its own state while the output register is still
// held by a stalled receiver; stalled results never change.
// Reset (synchronous, active low) empties both channels and restores tolerance 65
// and step limit 64.
module newton_square_root import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FIELD_BITS-1:0]   i_cfg_data,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [FIELD_BITS-1:0]   i_radicand,
    input  logic [FIELD_BITS-1:0]   i_start_guess,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [FIELD_BITS-1:0]   o_root,
    output logic [STEP_BITS-1:0]    o_steps_taken,
    output logic [OUTCOME_BITS-1:0] o_outcome
);

    // radicand + tolerance, formed without wrap
    localparam int BOUND_BITS = ((WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS) + 1;
    localparam int CMP_BITS   = (2 * WORD_BITS > BOUND_BITS) ? 2 * WORD_BITS : BOUND_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    t_state                  r_state;
    logic [FIELD_BITS-1:0]   r_tolerance;
    logic [STEP_BITS-1:0]    r_step_limit;
    logic [WORD_BITS-1:0]    r_x;
    logic [WORD_BITS-1:0]    r_g;
    logic [BOUND_BITS-1:0]   r_bound;
    logic [STEP_BITS-1:0]    r_steps;
    t_outcome                r_result;
    logic                    r_out_valid;
    logic [FIELD_BITS-1:0]   r_root;
    logic [STEP_BITS-1:0]    r_out_steps;
    t_outcome                r_out_outcome;

    logic [WORD_BITS-1:0]    in_x;
    logic [WORD_BITS-1:0]    in_g;
    logic                    unit_start;
    logic                    sqr_done;
    logic [2*WORD_BITS-1:0]  sqr_product;
    logic                    div_done;
    logic [WORD_BITS:0]      div_quot;
    logic [CMP_BITS-1:0]     sq_scaled;
    logic                    close_enough;
    logic [WORD_BITS+1:0]    step_sum;
    logic [WORD_BITS-1:0]    g_next;

    // Inputs are taken at the word size
    assign in_x = WORD_BITS'(i_radicand);
    assign in_g = WORD_BITS'(i_start_guess);

    // Both units start together; the divide is dropped if the test stops the loop
    assign unit_start = (r_state == ST_LOAD);

    nsr_sqr #(
        .WORD_BITS (WORD_BITS)
    ) u_sqr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (unit_start),
        .i_operand (r_g),
        .o_done    (sqr_done),
        .o_product (sqr_product)
    );

    nsr_div #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (unit_start),
        .i_dividend (r_x),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Stop test: floor(g^2 / 2^FRAC_BITS) <= radicand + tolerance (one-sided)
    assign sq_scaled    = CMP_BITS'(sqr_product >> FRAC_BITS);
    assign close_enough = (sq_scaled <= CMP_BITS'(r_bound));

    // Newton step: (g + q) / 2, saturated at the word maximum
    assign step_sum = {2'b00, r_g} + {1'b0, div_quot};
    assign g_next   = step_sum[WORD_BITS+1] ? '1 : step_sum[WORD_BITS:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_tolerance  <= TOL_RESET;
            r_step_limit <= LIMIT_RESET;
            r_x          <= '0;
            r_g          <= '0;
            r_steps      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                    CFG_STEP_LIMIT: r_step_limit <= i_cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end

            // drop the result once the receiver takes it, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= in_x;
                        r_g     <= in_g;
                        r_bound <= BOUND_BITS'(in_x) + BOUND_BITS'(r_tolerance);
                        r_steps <= '0;
                        if (in_g == '0) begin
                            // refuse a zero guess without dividing
                            r_result <= OUT_ZERO_GUESS;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_state  <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    if (sqr_done) begin
                        priority if (close_enough) begin
                            r_result <= OUT_CONVERGED;
                            r_state  <= ST_EMIT;
                        end else if (r_steps >= r_step_limit) begin
                            r_result <= OUT_LIMIT;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_state  <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        r_g     <= g_next;
                        r_steps <= r_steps + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_root        <= FIELD_BITS'(r_g);
                        r_out_steps   <= r_steps;
                        r_out_outcome <= r_result;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_root        = r_root;
    assign o_steps_taken = r_out_steps;
    assign o_outcome     = r_out_outcome;

endmodule

### hdl/nsr_chk.sv
`include "newton_square_root_defines.svh"

module nsr_chk import nsr_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [FIELD_BITS-1:0]   o_root,
    input logic [STEP_BITS-1:0]    o_steps_taken,
    input logic [OUTCOME_BITS-1:0] o_outcome
);

    logic                                          in_take;
    logic                                          zero_out;
    logic                                          zero_clear;
    logic                                          out_stalled;
    logic [FIELD_BITS+STEP_BITS+OUTCOME_BITS-1:0]  out_word;

    assign in_take     = i_in_valid && !o_in_stall;
    assign zero_out    = o_out_valid && (o_outcome == OUT_ZERO_GUESS);
    assign zero_clear  = (o_root == '0) && (o_steps_taken == '0);
    assign out_stalled = o_out_valid && i_out_stall;
    assign out_word    = {o_root, o_steps_taken, o_outcome};

    // a taken request keeps the block busy
    `NSR_ASSERT_NEXT(a_busy_after_take, in_take, o_in_stall, "request taken but block not busy")

    // a refused guess reports root zero after no steps
    `NSR_ASSERT_NOW(a_zero_guess_result, zero_out, zero_clear, "zero guess result not cleared")

    // only a refused guess can come out straight after acceptance
    `NSR_ASSERT_NEXT(a_no_early_result, in_take, !($rose(o_out_valid) && !zero_out), "result too early")

    // a stalled result holds
    `NSR_ASSERT_NEXT(a_hold_result, out_stalled, o_out_valid && $stable(out_word), "stalled result changed")

endmodule

bind newton_square_root nsr_chk u_nsr_chk (.*);

### tb/sv/newton_square_root_test.sv
module newton_square_root_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nsr_pkg::*;

    localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
    localparam logic [63:0] QUOT_SAT    = (64'd1 << (WORD_BITS_DEF + 1)) - 64'd1;
    localparam logic [63:0] WORD_SAT    = (64'd1 << WORD_BITS_DEF) - 64'd1;
    localparam int unsigned CYCLE_LIMIT = 16_000_000;
    localparam int          IDLE_PCT    = 10;

    // One result as the block hands it back
    typedef struct packed {
        logic [31:0] root;
        logic [7:0]  steps;
        t_outcome    outcome;
    } root_result_t;

    // Directed request: the settings it runs under, its fields and, where it is
    // obvious, the result typed in by hand
    typedef struct packed {
        logic [31:0] tol;
        logic [7:0]  limit;
        logic [31:0] radicand;
        logic [31:0] guess;
        logic        typed;
        logic [31:0] root;
        logic [7:0]  steps;
        t_outcome    outcome;
    } request_row_t;

    // Random phase: settings, number of requests, and whether both sides stay busy
    typedef struct packed {
        logic [31:0] tol;
        logic [7:0]  limit;
        logic [15:0] count;
        logic        quiet;
    } phase_t;

    localparam request_row_t DIRECTED [20] = '{
        // zero start guesses are refused outright
        '{32'd65, 8'd64, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 8'd0, OUT_ZERO_GUESS},
        '{32'd65, 8'd64, MAX32,         32'h0000_0000, 1'b1, 32'h0, 8'd0, OUT_ZERO_GUESS},
        // a guess at or below the root, or within the tolerance above it, passes the one-sided test at once
        '{32'd65, 8'd64, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h1, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, MAX32,         32'h0000_0001, 1'b1, 32'h1, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, 32'h0004_0000, 32'h0002_0000, 1'b1, 32'h0002_0000, 8'd0,
          OUT_CONVERGED},
        '{32'd65, 8'd64, 32'h0002_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 8'd0,
          OUT_CONVERGED},
        // full descents under the reset settings
        '{32'd65, 8'd64, 32'h0000_0000, MAX32,         1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, MAX32,         MAX32,         1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, MAX32,         32'h00FF_FFFF, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, 32'h0002_0000, 32'h0003_0000, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd65, 8'd64, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        // one step allowed, no tolerance: the step limit can cut the descent short
        '{32'd0, 8'd1, 32'h0000_0000, MAX32,         1'b1, 32'h7FFF_FFFF, 8'd1, OUT_LIMIT},
        '{32'd0, 8'd1, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 8'd0,
          OUT_CONVERGED},
        '{32'd0, 8'd1, 32'h0002_0000, 32'h0002_0000, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        // widest tolerance, then no tolerance, each with the largest step limit
        '{MAX32, 8'd255, 32'h0000_0000, MAX32,         1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{MAX32, 8'd255, MAX32,         MAX32,         1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd0, 8'd255, 32'h0002_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 8'd0, OUT_CONVERGED},
        '{32'd0, 8'd255, 32'h0003_0000, MAX32,         1'b0, 32'h0, 8'd0, OUT_CONVERGED}
    };

    // Keep the slow settings (no tolerance, 255 steps) to a handful of requests
    localparam phase_t PHASES [7] = '{
        '{32'd65,   8'd64,  16'd300, 1'b0},
        '{32'd0,    8'd255, 16'd12,  1'b0},
        '{MAX32,    8'd1,   16'd100, 1'b0},
        '{32'd0,    8'd1,   16'd100, 1'b0},
        '{32'd65,   8'd64,  16'd250, 1'b1},
        '{32'd4096, 8'd8,   16'd200, 1'b0},
        '{32'd1,    8'd32,  16'd60,  1'b0}
    };

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_we        = 1'b0;
    t_cfg_index   cfg_index     = CFG_TOLERANCE;
    logic [31:0]  cfg_data      = '0;
    logic         in_valid      = 1'b0;
    logic [31:0]  radicand      = '0;
    logic [31:0]  start_guess   = '0;
    logic         out_stall     = 1'b0;
    logic         in_stall;
    logic         out_valid;
    logic [31:0]  root;
    logic [7:0]   steps_taken;
    logic [1:0]   outcome;

    // Mirror of the block's registers
    logic [31:0]  tolerance_copy = TOL_RESET;
    logic [7:0]   limit_copy     = LIMIT_RESET;

    root_result_t pending_roots [$];
    bit           quiet          = 1'b0;
    int unsigned  cycle_count    = 0;
    int unsigned  n_mismatches   = 0;
    int unsigned  n_requests     = 0;
    int unsigned  n_results      = 0;
    int unsigned  n_writes       = 0;
    int unsigned  outcome_count [3] = '{0, 0, 0};

    newton_square_root dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_radicand    (radicand),
        .i_start_guess (start_guess),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_root        (root),
        .o_steps_taken (steps_taken),
        .o_outcome     (outcome)
    );

    always #1 clk = ~clk;

    // Work out the result the block should return: refuse a zero guess, else descend with
    // truncated Newton steps until the square no longer overshoots by more than the tolerance or the limit is hit
    function automatic root_result_t solve_root(input logic [31:0] rad,
                                                input logic [31:0] guess);
        root_result_t res;
        logic [63:0]  g;
        logic [63:0]  x;
        logic [63:0]  q;
        logic [63:0]  sum;
        int           n;
        bit           done;
        g    = {32'd0, guess};
        x    = {32'd0, rad};
        n    = 0;
        done = 1'b0;
        res.outcome = OUT_CONVERGED;
        if (guess == 32'd0) begin
            res.outcome = OUT_ZERO_GUESS;
            done = 1'b1;
        end
        while (!done) begin
            // the square of a 32-bit guess always fits in 64 bits: compare exactly
            if (((g * g) >> FRAC_BITS_DEF) <= x + {32'd0, tolerance_copy}) begin
                res.outcome = OUT_CONVERGED;
                done = 1'b1;
            end else if (n >= int'(limit_copy)) begin
                res.outcome = OUT_LIMIT;
                done = 1'b1;
            end else begin
                q = (x << FRAC_BITS_DEF) / g;
                if (q > QUOT_SAT) begin
                    q = QUOT_SAT;
                end
                sum = (g + q) >> 1;
                g = (sum > WORD_SAT) ? WORD_SAT : sum;
                n++;
            end
        end
        res.root  = g[31:0];
        res.steps = 8'(n);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        n_mismatches++;
        $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what,
                 got, want);
    endtask

    // Offer one request, hold it until taken, then queue the result it must produce
    task automatic offer_request(input logic [31:0] rad, input logic [31:0] guess,
                                 input logic typed, input root_result_t typed_result);
        root_result_t predicted;
        // idle the request channel now and then, unless the stretch is meant to be busy
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        radicand    <= rad;
        start_guess <= guess;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predicted = solve_root(rad, guess);
        pending_roots.push_back(typed ? typed_result : predicted);
        n_requests++;
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending_roots.size() != 0);
    endtask

    // Write both registers on consecutive edges; the block is idle by now
    task automatic load_settings(input logic [31:0] tol, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= tol;
        @(posedge clk);
        cfg_index <= CFG_STEP_LIMIT;
        cfg_data  <= {24'd0, limit};
        @(posedge clk);
        cfg_we         <= 1'b0;
        tolerance_copy  = tol;
        limit_copy      = limit;
        n_writes       += 2;
    endtask

    // Result side: check each accepted result against the oldest queued one, then
    // decide at random whether to stall the next edge
    always @(posedge clk) begin
        root_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (pending_roots.size() == 0) begin
                flag_mismatch("result with no request outstanding", root, 32'd0);
            end else begin
                want = pending_roots.pop_front();
                outcome_count[int'(want.outcome)]++;
                if (root !== want.root) begin
                    flag_mismatch("root", root, want.root);
                end
                if (steps_taken !== want.steps) begin
                    flag_mismatch("steps taken", {24'd0, steps_taken}, {24'd0, want.steps});
                end
                if (outcome !== want.outcome) begin
                    flag_mismatch("outcome", {30'd0, outcome}, {30'd0, want.outcome});
                end
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end the run if it goes far beyond the slowest correct run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending_roots.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        root_result_t typed_result;
        root_result_t none;
        logic [63:0]  r;
        logic [31:0]  rad;
        logic [31:0]  guess;
        int           i;
        int           p;
        int           k;
        none = '{32'd0, 8'd0, OUT_CONVERGED};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: the first rows run under the reset settings, so those
        // values are checked without any write; change settings only when idle
        for (i = 0; i < 20; i++) begin
            if (DIRECTED[i].tol != tolerance_copy || DIRECTED[i].limit != limit_copy) begin
                wait_for_results();
                load_settings(DIRECTED[i].tol, DIRECTED[i].limit);
            end
            typed_result = '{DIRECTED[i].root, DIRECTED[i].steps, DIRECTED[i].outcome};
            offer_request(DIRECTED[i].radicand, DIRECTED[i].guess, DIRECTED[i].typed,
                          typed_result);
        end

        // Random phases, each under its own settings
        for (p = 0; p < 7; p++) begin
            wait_for_results();
            load_settings(PHASES[p].tol, PHASES[p].limit);
            quiet = PHASES[p].quiet;
            for (k = 0; k < int'(PHASES[p].count); k++) begin
                case ($urandom_range(19))
                    0: begin
                        // zero start guess
                        rad   = $urandom;
                        guess = 32'd0;
                    end
                    1, 2: begin
                        // extreme radicands against any guess
                        case ($urandom_range(3))
                            0:       rad = 32'd0;
                            1:       rad = 32'd1;
                            2:       rad = 32'h8000_0000;
                            default: rad = MAX32;
                        endcase
                        guess = $urandom >> $urandom_range(0, 16);
                    end
                    3, 4, 5, 6, 7, 8, 9: begin
                        // square a chosen root and start just around it
                        r     = 64'($urandom_range(0, 32'h00FF_FFFF));
                        rad   = 32'((r * r) >> FRAC_BITS_DEF);
                        guess = r[31:0] + 32'($urandom_range(0, 96)) - 32'd16;
                    end
                    default: begin
                        // far guesses of every magnitude
                        rad   = $urandom >> $urandom_range(0, 31);
                        guess = $urandom >> $urandom_range(0, 8);
                    end
                endcase
                offer_request(rad, guess, 1'b0, none);
                // hold off now and then until everything has come back
                if (k % 100 == 99) begin
                    wait_for_results();
                end
            end
        end
        quiet = 1'b0;

        wait_for_results();
        // wait on for any stray result; a zero guess is the fastest to answer
        repeat (100) @(posedge clk);

        $display("covered %0d requests and %0d results over %0d register writes",
                 n_requests, n_results, n_writes);
        $display("outcomes: %0d converged, %0d step limit, %0d zero guess; %0d mismatches",
                 outcome_count[0], outcome_count[1], outcome_count[2], n_mismatches);
        if (n_mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/nsr_pkg.sv
hdl/nsr_sqr.sv
hdl/nsr_div.sv
hdl/newton_square_root.sv
hdl/nsr_chk.sv
tb/sv/newton_square_root_test.sv
